/* sv/console_link_output_framer_core_defines.svh */
// Assertion macros shared by the framer modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef CONSOLE_LINK_OUTPUT_FRAMER_CORE_DEFINES_SVH
`define CONSOLE_LINK_OUTPUT_FRAMER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define CLFR_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CLFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/clfr_pkg.sv */
package clfr_pkg;

  localparam int CharW  = 7;
  localparam int DelayW = 20;
  localparam int PrioW  = 3;

  localparam logic [CharW-1:0]  CHAR_MASK       = 7'o177;
  localparam logic [CharW-1:0]  PORT_MASK       = 7'o147;
  localparam logic [CharW-1:0]  PORT_MATCH      = 7'o140;
  localparam logic [7:0]        READY_BIT       = 8'o100;
  localparam logic [7:0]        REQ_BASE        = 8'o200;
  localparam int                INIT_BIT_POS    = 7;
  localparam logic [DelayW-1:0] DELAY_RESET     = 20'd1000;

  localparam logic [CharW-1:0]  START_CHAR      = 7'd1;
  localparam logic [CharW-1:0]  STATUS_CHAR     = 7'd0;
  localparam logic [CharW-1:0]  TEXT_START_CHAR = 7'd2;
  localparam logic [CharW-1:0]  TEXT_END_CHAR   = 7'd3;

  typedef enum logic [2:0] {
    KIND_CLEAR      = 3'd0,
    KIND_COND_SET   = 3'd1,
    KIND_DATA_CLEAR = 3'd2,
    KIND_DATA_SET   = 3'd3,
    KIND_STATUS_RD  = 3'd4,
    KIND_TICK       = 3'd5
  } kind_t;

  typedef enum logic [5:0] {
    PH_START     = 6'b000001,
    PH_PORT      = 6'b000010,
    PH_STATUS    = 6'b000100,
    PH_TEXTSTART = 6'b001000,
    PH_TEXT      = 6'b010000,
    PH_CHECKSUM  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic [CharW-1:0] int_request;
    logic             text_valid;
    logic [CharW-1:0] text_char;
    logic [2:0]       text_port;
    logic             checksum_error;
    logic [CharW-1:0] checksum_value;
  } result_t;

endpackage

/* sv/clfr_if.sv */
interface clfr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] bus_data;

  modport source (output valid, output kind, output bus_data, input ready);
  modport sink   (input valid, input kind, input bus_data, output ready);
endinterface

interface clfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [6:0] int_request;
  logic       text_valid;
  logic [6:0] text_char;
  logic [2:0] text_port;
  logic       checksum_error;
  logic [6:0] checksum_value;

  modport source (output valid, output read_data, output int_request, output text_valid,
                  output text_char, output text_port, output checksum_error,
                  output checksum_value, input ready);
  modport sink   (input valid, input read_data, input int_request, input text_valid,
                  input text_char, input text_port, input checksum_error,
                  input checksum_value, output ready);
endinterface

interface clfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] char_delay;

  modport source (output valid, output char_delay, input ready);
  modport sink   (input valid, input char_delay, output ready);
endinterface

/* sv/clfr_core.sv */
`include "console_link_output_framer_core_defines.svh"

module clfr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  logic [2:0]                    item_kind,
  input  logic [7:0]                    item_data,
  input  logic                          cfg_we,
  input  logic [clfr_pkg::DelayW-1:0]   cfg_data,
  output clfr_pkg::result_t             result
);
  import clfr_pkg::*;

  logic [DelayW-1:0] char_delay_r;
  logic [PrioW-1:0]  prio_r, prio_nxt;
  logic              ready_r, ready_nxt;
  logic              busy_r, busy_nxt;
  logic [CharW-1:0]  hold_r, hold_nxt;
  logic [CharW-1:0]  xor_r, xor_nxt;
  logic [2:0]        port_r, port_nxt;
  phase_t            phase_r, phase_nxt;
  logic [DelayW-1:0] delay_r, delay_nxt;
  kind_t             kind;

  assign kind = kind_t'(item_kind);

  always_comb begin
    logic [CharW-1:0] merged;
    logic [CharW-1:0] rotated;
    logic [7:0]       req_full;
    merged   = hold_r | (item_data[CharW-1:0] ^ CHAR_MASK);
    rotated  = {merged[CharW-2:0], merged[CharW-1]};
    prio_nxt  = prio_r;
    ready_nxt = ready_r;
    busy_nxt  = busy_r;
    hold_nxt  = hold_r;
    xor_nxt   = xor_r;
    port_nxt  = port_r;
    phase_nxt = phase_r;
    delay_nxt = delay_r;
    result    = '0;

    if (item_valid) begin
      unique case (kind)
        KIND_CLEAR: begin
          prio_nxt  = '0;
          ready_nxt = 1'b0;
          busy_nxt  = 1'b0;
          hold_nxt  = '0;
          phase_nxt = PH_START;
        end
        KIND_COND_SET: begin
          prio_nxt = prio_r | item_data[PrioW-1:0];
          if (item_data[INIT_BIT_POS]) begin
            busy_nxt  = 1'b0;
            ready_nxt = 1'b1;
          end
        end
        KIND_DATA_CLEAR: begin
          hold_nxt  = '0;
          ready_nxt = 1'b0;
          busy_nxt  = 1'b1;
        end
        KIND_DATA_SET: begin
          hold_nxt  = rotated;
          xor_nxt   = xor_r ^ rotated;
          delay_nxt = char_delay_r;
        end
        KIND_STATUS_RD: begin
          result.read_data = {5'd0, prio_r} | (ready_r ? READY_BIT : 8'd0);
        end
        KIND_TICK: begin
          if (delay_r != '0) begin
            delay_nxt = delay_r - 1'b1;
          end else if (busy_r) begin
            // The held character advances the frame parser, keeps it in its phase, or sends it back to the start phase.
            unique case (phase_r)
              PH_START: begin
                if (hold_r == START_CHAR) begin
                  phase_nxt = PH_PORT;
                  xor_nxt   = '0;
                end
              end
              PH_PORT: begin
                if ((hold_r & PORT_MASK) == PORT_MATCH) begin
                  phase_nxt = PH_STATUS;
                  port_nxt  = hold_r[5:3];
                end else begin
                  phase_nxt = PH_START;
                end
              end
              PH_STATUS: begin
                phase_nxt = (hold_r == STATUS_CHAR) ? PH_TEXTSTART : PH_START;
              end
              PH_TEXTSTART: begin
                if (hold_r == TEXT_START_CHAR) begin
                  phase_nxt = PH_TEXT;
                end
              end
              PH_TEXT: begin
                if (hold_r == TEXT_END_CHAR) begin
                  phase_nxt = PH_CHECKSUM;
                end else begin
                  result.text_valid = 1'b1;
                  result.text_char  = hold_r;
                  result.text_port  = port_r;
                end
              end
              PH_CHECKSUM: begin
                result.checksum_error = (xor_r != '0);
                result.checksum_value = xor_r;
                phase_nxt             = PH_START;
              end
              default: begin
                phase_nxt = PH_START;
              end
            endcase
            ready_nxt = 1'b1;
            busy_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    req_full = REQ_BASE >> prio_nxt;
    if (ready_nxt && prio_nxt != '0) begin
      result.int_request = req_full[CharW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_delay_r <= DELAY_RESET;
      prio_r       <= '0;
      ready_r      <= 1'b0;
      busy_r       <= 1'b0;
      hold_r       <= '0;
      xor_r        <= '0;
      port_r       <= '0;
      phase_r      <= PH_START;
      delay_r      <= '0;
    end else begin
      if (cfg_we) begin
        char_delay_r <= cfg_data;
      end
      prio_r  <= prio_nxt;
      ready_r <= ready_nxt;
      busy_r  <= busy_nxt;
      hold_r  <= hold_nxt;
      xor_r   <= xor_nxt;
      port_r  <= port_nxt;
      phase_r <= phase_nxt;
      delay_r <= delay_nxt;
    end
  end

  // Ready and busy are never set together.
  `CLFR_ASSERT(a_ready_busy_excl, !(ready_r && busy_r), "ready and busy both set")
  `CLFR_ASSERT_NEXT(a_delay_load, item_valid && kind == KIND_DATA_SET, delay_r == $past(char_delay_r), "delay not reloaded on data set")
  `CLFR_ASSERT_IMPL(a_text_phase, result.text_valid, phase_r == PH_TEXT && busy_r, "text delivered outside text phase")

endmodule

/* sv/clfr_out_stage.sv */
`include "console_link_output_framer_core_defines.svh"

module clfr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  clfr_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              rcv_ready,
  output clfr_pkg::result_t out_data
);
  import clfr_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (rcv_ready || !main_v_r) begin
      // Main register is free: the skid entry drains first, it is older.
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  `CLFR_ASSERT(a_skid_behind_main, !skid_v_r || main_v_r, "skid entry held with empty output")
  `CLFR_ASSERT_NEXT(a_push_lands, push && can_push, main_v_r, "accepted transaction lost")
  `CLFR_ASSERT_NEXT(a_skid_drains, skid_v_r && rcv_ready, !skid_v_r && main_r == $past(skid_r), "skid entry not moved forward")

endmodule

/* sv/console_link_output_framer_core.sv */
// Console link output framer.
// Channels: in_chan takes one transaction per item (kind, bus_data); out_chan
// returns exactly one result transaction per accepted item, in order; cfg_chan
// writes the 20-bit character delay and is always ready.
// Each item is applied to the controller state in the cycle it is accepted, and
// its result is registered in the output stage before it shows on out_chan.
// Throughput is one item per clock while in_chan.ready is high, set by the
// state update of the small control registers.
// A two-entry output stage (output register plus skid register) lets the block
// keep accepting while a result waits. If the receiver stalls, one more item is
// taken into the skid register and then in_chan.ready drops until the receiver
// takes a result.
// Reset (rst_n low at a clock edge) empties the output stage, clears all
// controller state and sets the character delay to 1000 ticks.
// Configuration should be written only when no results are outstanding.
module console_link_output_framer_core (
  input logic        clk,
  input logic        rst_n,
  clfr_in_if.sink    in_chan,
  clfr_out_if.source out_chan,
  clfr_cfg_if.sink   cfg_chan
);
  import clfr_pkg::*;

  logic    accept;
  logic    can_push;
  result_t result;
  result_t out_data;

  assign in_chan.ready  = can_push;
  assign accept         = in_chan.valid && can_push;
  assign cfg_chan.ready = 1'b1;

  clfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (accept),
    .item_kind  (in_chan.kind),
    .item_data  (in_chan.bus_data),
    .cfg_we     (cfg_chan.valid),
    .cfg_data   (cfg_chan.char_delay),
    .result     (result)
  );

  clfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_chan.valid),
    .rcv_ready (out_chan.ready),
    .out_data  (out_data)
  );

  assign out_chan.read_data      = out_data.read_data;
  assign out_chan.int_request    = out_data.int_request;
  assign out_chan.text_valid     = out_data.text_valid;
  assign out_chan.text_char      = out_data.text_char;
  assign out_chan.text_port      = out_data.text_port;
  assign out_chan.checksum_error = out_data.checksum_error;
  assign out_chan.checksum_value = out_data.checksum_value;

endmodule
